// ----- hdl/gf4md_pkg.sv -----
// Shared types, constants and field arithmetic for the GF(4) minimum-distance checker.
`timescale 1ns / 1ps
package gf4md_pkg;

    localparam int CODE_LENGTH_DEF = 22;
    localparam int BASE_ROWS_DEF   = 5;
    localparam int MAX_BASE_ROWS   = 5;

    localparam int ROW_W     = 44;
    localparam int REG_IDX_W = 3;
    localparam int THR_W     = 5;
    localparam int COUNT_W   = 12;
    localparam int MIN_W     = 5;

    localparam logic [THR_W-1:0] ABORT_BELOW_RST   = 5'd10;
    localparam logic [THR_W-1:0] TARGET_WEIGHT_RST = 5'd12;

    localparam logic [REG_IDX_W-1:0] REG_ABORT_BELOW   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_WEIGHT = 3'd6;

    typedef logic [ROW_W-1:0] row_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_COMB,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // GF(4) product, symbols 0, 1, w, w^2 coded 0..3
    localparam logic [1:0] GF_MUL [4][4] = '{
        '{2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd3, 2'd1},
        '{2'd0, 2'd3, 2'd1, 2'd2}
    };

    function automatic logic [1:0] gf_mul(input logic [1:0] c, input logic [1:0] s);
        return GF_MUL[c][s];
    endfunction

endpackage

// ----- hdl/gf4md_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gf4md_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/gf4_code_min_distance_check_unit.sv -----
// Top level: minimum-distance and target-weight count of a six-row GF(4) code.
//
//   port group  dir  tdata / tuser (low bit first)                     note
//   s_          in   tdata: row_six[43:0], pad to 48                   candidate row
//   m_          out  tdata: min_distance[4:0], target_count[16:5]      one per row
//                    tuser: aborted
//   cfg_        in   index 0-4 base rows, 5 abort_below, 6 target_weight
//
// Each item runs a base pass and then the combined passes, one codeword per cycle:
// base words written to the codeword RAM, combined words read back through its single
// read port. An abort ends the item at the offending word.
// Reset is synchronous; configuration returns to its defaults and the RAM needs
// no clearing since every item refills it. Input is taken only when idle; a
// waiting result does not block the next input, only the next result.
`timescale 1ns / 1ps
module gf4_code_min_distance_check_unit #(
    parameter int CODE_LENGTH = gf4md_pkg::CODE_LENGTH_DEF,
    parameter int BASE_ROWS   = gf4md_pkg::BASE_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // row_six
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // min_distance, target_count
    output logic                            m_tuser,   // aborted
    input  logic                            cfg_wr_en,
    input  logic [gf4md_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [gf4md_pkg::ROW_W-1:0]     cfg_wdata
);
    import gf4md_pkg::*;

    localparam int W     = 2 * CODE_LENGTH;
    localparam int IW    = 2 * BASE_ROWS;
    localparam int DEPTH = 1 << IW;
    localparam int DW    = $clog2(CODE_LENGTH + 2);

    typedef logic [W-1:0] word_t;

    function automatic word_t fit_row(input row_t r);
        logic [63:0] ext;
        ext = {{(64 - ROW_W){1'b0}}, r};
        return ext[W-1:0];
    endfunction

    function automatic word_t scale_word(input word_t w, input logic [1:0] c);
        word_t r;
        for (int j = 0; j < CODE_LENGTH; j++) begin
            r[2*j +: 2] = gf_mul(c, w[2*j +: 2]);
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    row_t             base_row_reg [MAX_BASE_ROWS];
    logic [THR_W-1:0] abort_below_reg, target_weight_reg;

    word_t            six_reg;
    logic [IW-1:0]    cnt_reg;
    logic [1:0]       mult_reg;
    word_t            bword_reg;
    logic             bvld_reg;
    logic             cvld_reg;
    word_t            sr_d_reg;
    logic [DW-1:0]    dmin_reg;
    logic [COUNT_W-1:0] count_reg;
    logic             stop_reg;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;
    logic             m_tuser_reg;

    word_t            base_word, rd_data, wword;
    logic             wvld, hit, abort_hit, cnt_last, out_free;
    logic [DW-1:0]    wt, dmin_next;
    logic             ram_we, issue, accept, load_out;
    logic [MIN_W-1:0] min_out;

    always_comb begin
        base_word = '0;
        for (int r = 0; r < BASE_ROWS; r++) begin
            base_word = base_word ^ scale_word(fit_row(base_row_reg[r]), cnt_reg[2*r +: 2]);
        end
    end

    gf4md_ram #(
        .WIDTH(W),
        .DEPTH(DEPTH)
    ) u_cw_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg),
        .wr_data (base_word),
        .rd_addr (cnt_reg),
        .rd_data (rd_data)
    );

    // weighing stage
    always_comb begin
        logic [CODE_LENGTH-1:0] nz;
        wword = cvld_reg ? (rd_data ^ sr_d_reg) : bword_reg;
        wvld  = cvld_reg | bvld_reg;
        for (int j = 0; j < CODE_LENGTH; j++) begin
            nz[j] = wword[2*j] | wword[2*j+1];
        end
        wt        = DW'($countones(nz));
        dmin_next = (wvld && (wt < dmin_reg)) ? wt : dmin_reg;
        hit       = wvld && (6'(wt) == 6'(target_weight_reg));
        abort_hit = cvld_reg && (6'(dmin_next) < 6'(abort_below_reg));
    end

    assign cnt_last = (cnt_reg == {IW{1'b1}});
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_BASE;
            ST_BASE:  if (cnt_last) state_next = ST_COMB;
            ST_COMB: begin
                if (abort_hit) begin
                    state_next = ST_DONE;
                end else if (cnt_last && (mult_reg == 2'd3)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        ram_we   = (state_reg == ST_BASE);
        issue    = (state_reg == ST_COMB) && !abort_hit;
        load_out = (state_reg == ST_DONE) && out_free;
    end

    assign accept  = s_tvalid && s_tready;
    assign min_out = (6'(dmin_reg) > 6'd31) ? 5'd31 : MIN_W'(dmin_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            abort_below_reg   <= ABORT_BELOW_RST;
            target_weight_reg <= TARGET_WEIGHT_RST;
            for (int r = 0; r < MAX_BASE_ROWS; r++) begin
                base_row_reg[r] <= '0;
            end
            bvld_reg     <= 1'b0;
            cvld_reg     <= 1'b0;
            stop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (32'(cfg_index) < MAX_BASE_ROWS) begin
                    base_row_reg[cfg_index] <= cfg_wdata;
                end else if (cfg_index == REG_ABORT_BELOW) begin
                    abort_below_reg <= cfg_wdata[THR_W-1:0];
                end else if (cfg_index == REG_TARGET_WEIGHT) begin
                    target_weight_reg <= cfg_wdata[THR_W-1:0];
                end
            end
            bvld_reg <= ram_we && (cnt_reg != '0);
            cvld_reg <= issue;
            if (accept) begin
                stop_reg <= 1'b0;
            end else if (abort_hit) begin
                stop_reg <= 1'b1;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            six_reg   <= fit_row(s_tdata[ROW_W-1:0]);
            cnt_reg   <= '0;
            mult_reg  <= 2'd1;
            dmin_reg  <= DW'(CODE_LENGTH + 1);
            count_reg <= '0;
        end else begin
            if (ram_we || issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (issue && cnt_last) begin
                mult_reg <= mult_reg + 2'd1;
            end
            if (wvld) begin
                dmin_reg <= dmin_next;
            end
            if (hit) begin
                count_reg <= count_reg + 1'b1;
            end
        end
        bword_reg <= base_word;
        sr_d_reg  <= scale_word(six_reg, mult_reg);
        if (load_out) begin
            m_tdata_reg <= {7'd0, (stop_reg ? {COUNT_W{1'b0}} : count_reg), min_out};
            m_tuser_reg <= stop_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_abort_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[16:5] == '0)
        else $error("aborted result carries a nonzero count");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cvld_reg && !bvld_reg)
        else $error("codeword still in flight while idle");

    a_read_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && cvld_reg |-> $past(state_reg == ST_COMB))
        else $error("RAM read pending outside the combined pass");

    a_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[4:0]) <= CODE_LENGTH)
        else $error("minimum distance beyond code length");

endmodule

// ----- dv/gf4md_checker.sv -----
// Checker: mirrors configuration, predicts each distance report and compares results.
`timescale 1ns / 1ps
module gf4md_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // row_six
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,   // min_distance, target_count
    input  logic                            m_tuser,   // aborted
    input  logic                            cfg_wr_en,
    input  logic [gf4md_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [gf4md_pkg::ROW_W-1:0]     cfg_wdata,
    output int                              mismatches,
    output int                              awaiting
);
    import gf4md_pkg::*;

    localparam int   SYMBOLS     = CODE_LENGTH_DEF;
    localparam int   NUM_ROWS    = BASE_ROWS_DEF;
    localparam int   NUM_BASE    = 1 << (2 * BASE_ROWS_DEF);
    localparam row_t ALL_ONE_SYM = {SYMBOLS{2'b01}};

    typedef struct packed {
        logic [MIN_W-1:0]   min_wt;
        logic [COUNT_W-1:0] wt_count;
        logic               stopped;
    } distance_report_t;

    row_t             base_row [MAX_BASE_ROWS];
    logic [THR_W-1:0] abort_thr;
    logic [THR_W-1:0] target_wt;
    distance_report_t pending_reports [$];

    // symbols coded 1, 2, 3 stand for w^0, w^1, w^2
    function automatic logic [1:0] gf4_product(input logic [1:0] a, input logic [1:0] b);
        int l;
        if (a == 2'd0 || b == 2'd0)
            return 2'd0;
        l = (int'(a) + int'(b) - 2) % 3;
        return 2'(l + 1);
    endfunction

    function automatic row_t scale_row(input row_t w, input logic [1:0] c);
        row_t r;
        int   j;
        r = '0;
        for (j = 0; j < SYMBOLS; j++)
            r[2*j +: 2] = gf4_product(c, w[2*j +: 2]);
        return r;
    endfunction

    function automatic int symbol_weight(input row_t w);
        return $countones((w | (w >> 1)) & ALL_ONE_SYM);
    endfunction

    function automatic distance_report_t enumerate_code(input row_t six);
        row_t             scaled [NUM_ROWS][4];
        row_t             words [NUM_BASE];
        row_t             six_mult;
        int               dmin, hits, wt, r, i, a;
        bit               stop;
        distance_report_t rep;
        for (r = 0; r < NUM_ROWS; r++)
            for (a = 0; a < 4; a++)
                scaled[r][a] = scale_row(base_row[r], 2'(a));
        for (i = 0; i < NUM_BASE; i++) begin
            words[i] = '0;
            for (r = 0; r < NUM_ROWS; r++)
                words[i] ^= scaled[r][(i >> (2 * r)) & 3];
        end
        dmin = SYMBOLS + 1;
        hits = 0;
        stop = 1'b0;
        // base words never trigger the early stop
        for (i = 1; i < NUM_BASE; i++) begin
            wt = symbol_weight(words[i]);
            if (wt < dmin)
                dmin = wt;
            if (wt == int'(target_wt))
                hits++;
        end
        for (a = 1; a < 4 && !stop; a++) begin
            six_mult = scale_row(six, 2'(a));
            for (i = 0; i < NUM_BASE && !stop; i++) begin
                wt = symbol_weight(words[i] ^ six_mult);
                if (wt < dmin)
                    dmin = wt;
                if (wt == int'(target_wt))
                    hits++;
                if (dmin < int'(abort_thr))
                    stop = 1'b1;
            end
        end
        if (dmin > 31)
            dmin = 31;
        rep.min_wt   = MIN_W'(dmin);
        rep.wt_count = stop ? '0 : COUNT_W'(hits);
        rep.stopped  = stop;
        return rep;
    endfunction

    always @(posedge aclk) begin : monitor
        distance_report_t want;
        int               r;
        if (!aresetn) begin
            for (r = 0; r < MAX_BASE_ROWS; r++)
                base_row[r] = '0;
            abort_thr = ABORT_BELOW_RST;
            target_wt = TARGET_WEIGHT_RST;
            pending_reports.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index < REG_IDX_W'(MAX_BASE_ROWS))
                    base_row[cfg_index] = cfg_wdata;
                else if (cfg_index == REG_ABORT_BELOW)
                    abort_thr = cfg_wdata[THR_W-1:0];
                else if (cfg_index == REG_TARGET_WEIGHT)
                    target_wt = cfg_wdata[THR_W-1:0];
            end
            if (s_tvalid && s_tready)
                pending_reports.push_back(enumerate_code(s_tdata[ROW_W-1:0]));
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    $display("%0t: unexpected transfer: min_distance %0d target_count %0d aborted %0b",
                             $time, m_tdata[4:0], m_tdata[16:5], m_tuser);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[4:0] !== want.min_wt) begin
                        $display("%0t: min_distance expected %0d, got %0d",
                                 $time, want.min_wt, m_tdata[4:0]);
                        mismatches++;
                    end
                    if (m_tdata[16:5] !== want.wt_count) begin
                        $display("%0t: target_count expected %0d, got %0d",
                                 $time, want.wt_count, m_tdata[16:5]);
                        mismatches++;
                    end
                    if (m_tuser !== want.stopped) begin
                        $display("%0t: aborted expected %0b, got %0b",
                                 $time, want.stopped, m_tuser);
                        mismatches++;
                    end
                end
            end
        end
        awaiting = pending_reports.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives candidate rows, configuration and back-pressure, and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import gf4md_pkg::*;

    localparam int   HOLD_AT       = 30;
    localparam int   HOLD_CYCLES   = 15000;
    localparam int   DRAIN_CYCLES  = 4200;
    localparam int   RANDOM_PHASES = 4;
    localparam int   PHASE_ITEMS   = 31;
    localparam int   NUM_ROWS      = BASE_ROWS_DEF;
    localparam int   SYMBOLS       = CODE_LENGTH_DEF;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam row_t ALL_ONE_SYM   = {SYMBOLS{2'b01}};
    localparam row_t ALL_W_SYM     = {SYMBOLS{2'b10}};

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;   // row_six
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [23:0]          m_tdata;          // min_distance, target_count
    logic                 m_tuser;          // aborted
    logic                 cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    row_t                 cfg_wdata = '0;

    int   mismatches;
    int   awaiting;
    int   results_taken = 0;
    bit   steady = 1'b0;
    row_t rows_now [NUM_ROWS];

    always #2 aclk = ~aclk;

    gf4_code_min_distance_check_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    gf4md_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            results_taken <= results_taken + 1;
    end

    function automatic row_t any_row();
        return row_t'({$urandom(), $urandom()});
    endfunction

    function automatic row_t thin_row(input row_t r, input int keep_pct);
        int j;
        for (j = 0; j < SYMBOLS; j++)
            if (int'($urandom_range(99)) >= keep_pct)
                r[2*j +: 2] = 2'd0;
        return r;
    endfunction

    // sum of some base rows, lightly disturbed: gives low-weight codewords
    function automatic row_t code_mix();
        row_t v;
        int   r, n;
        v = '0;
        for (r = 0; r < NUM_ROWS; r++)
            if ($urandom_range(1))
                v ^= rows_now[r];
        n = $urandom_range(2);
        for (r = 0; r < n; r++)
            v[2*$urandom_range(SYMBOLS-1) +: 2] = 2'($urandom_range(3));
        return v;
    endfunction

    function automatic row_t pick_row();
        int k;
        k = $urandom_range(99);
        if (k < 65)
            return any_row();
        if (k < 80)
            return thin_row(any_row(), $urandom_range(20, 70));
        if (k < 92)
            return code_mix();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return ALL_ONE_SYM;
            default: return ALL_W_SYM;
        endcase
    endfunction

    function automatic int idle_len();
        int k;
        k = $urandom_range(99);
        if (steady || k < 70)
            return 0;
        if (k < 90)
            return $urandom_range(1, 4);
        if (k < 98)
            return $urandom_range(5, 40);
        return $urandom_range(100, 400);
    endfunction

    // all tasks below start and end on a falling edge
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input row_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_limits(input logic [THR_W-1:0] abort_at, input logic [THR_W-1:0] tgt);
        write_reg(REG_ABORT_BELOW, row_t'(abort_at));
        write_reg(REG_TARGET_WEIGHT, row_t'(tgt));
    endtask

    task automatic load_rows();
        int r;
        for (r = 0; r < NUM_ROWS; r++)
            write_reg(REG_IDX_W'(r), rows_now[r]);
    endtask

    task automatic push_row(input row_t r, input int idle);
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaiting != 0)
            @(negedge aclk);
    endtask

    initial begin : receiver
        int  run, gap, k;
        bit  held;
        held = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            run = ($urandom_range(99) < 85) ? $urandom_range(1, 20) : $urandom_range(500, 5000);
            m_tready <= 1'b1;
            repeat (run) @(negedge aclk);
            if (!held && results_taken >= HOLD_AT) begin
                // long hold-off: the block fills up and must stall its input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                k = $urandom_range(99);
                if (k < 20)
                    gap = 0;
                else if (k < 60)
                    gap = $urandom_range(1, 3);
                else if (k < 90)
                    gap = $urandom_range(4, 20);
                else
                    gap = $urandom_range(50, 300);
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int               p, n, r, k;
        logic [THR_W-1:0] abort_at, tgt;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero base rows: every base word weighs 0, so the defaults stop at once
        push_row('0, 0);
        push_row('1, 1);
        push_row(any_row(), 0);
        settle();
        // never stop, count weight 0: all-zero row gives the full count
        set_limits(5'd0, 5'd0);
        push_row('0, 0);
        push_row('1, 2);
        settle();
        set_limits(5'd0, 5'd22);
        write_reg(REG_SPARE, any_row());
        push_row('1, 0);
        push_row(ALL_ONE_SYM, 0);
        settle();

        // dependent base rows give zero-weight words
        rows_now[0] = '1;
        rows_now[1] = any_row();
        rows_now[2] = ALL_ONE_SYM;
        rows_now[3] = ALL_W_SYM;
        rows_now[4] = any_row();
        load_rows();
        set_limits(5'd23, 5'd31);
        push_row(any_row(), 0);
        settle();
        set_limits(5'd31, 5'd31);
        push_row(any_row(), 0);
        settle();
        set_limits(5'd0, 5'd22);
        push_row(any_row(), 3);
        settle();

        for (r = 0; r < NUM_ROWS; r++)
            rows_now[r] = any_row();
        load_rows();
        set_limits(5'd0, 5'd12);
        push_row(rows_now[0], 0);
        push_row('0, 0);
        push_row(any_row(), 0);
        push_row(any_row(), 0);
        settle();
        set_limits(ABORT_BELOW_RST, TARGET_WEIGHT_RST);
        for (n = 0; n < 3; n++)
            push_row(any_row(), idle_len());
        settle();
        set_limits(5'd5, 5'd6);
        push_row(thin_row(any_row(), 40), 0);
        push_row(thin_row(any_row(), 60), 0);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            for (r = 0; r < NUM_ROWS; r++) begin
                k = $urandom_range(99);
                if (k < 80 || p == RANDOM_PHASES - 1)
                    rows_now[r] = any_row();
                else if (k < 90)
                    rows_now[r] = thin_row(any_row(), $urandom_range(30, 80));
                else
                    rows_now[r] = $urandom_range(1) ? '0 : '1;
            end
            load_rows();
            k = $urandom_range(99);
            if (p == RANDOM_PHASES - 1)
                abort_at = THR_W'($urandom_range(0, 8));
            else if (k < 30)
                abort_at = 5'd0;
            else if (k < 80)
                abort_at = THR_W'($urandom_range(1, 10));
            else
                abort_at = THR_W'($urandom_range(11, 31));
            tgt = THR_W'(($urandom_range(9) < 7) ? $urandom_range(6, 14) : $urandom_range(0, 31));
            set_limits(abort_at, tgt);
            steady = (p == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
                push_row(pick_row(), idle_len());
            settle();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && awaiting == 0)
            $display("gf4_code_min_distance_check_unit test passed");
        else
            $display("gf4_code_min_distance_check_unit test failed");
        $finish;
    end

    initial begin : watchdog
        #12000000;
        $display("gf4_code_min_distance_check_unit test failed");
        $finish;
    end

endmodule
